/* design/rbt_pkg.sv */
// Shared types and constants for the resource barrier tracker.
package rbt_pkg;

  // Default number of table entries.
  localparam int RESOURCES_DEF = 256;

  // Item opcodes.
  localparam logic OP_DEFINE = 1'b0;
  localparam logic OP_USE    = 1'b1;

  // One input beat.
  typedef struct packed {
    logic        opcode;
    logic [7:0]  resource;
    logic [30:0] layout;
    logic [63:0] stages;
    logic [63:0] access;
    logic        is_write;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic        barrier;
    logic [63:0] src_stages;
    logic [63:0] src_access;
    logic [63:0] dst_stages;
    logic [63:0] dst_access;
    logic [30:0] old_layout;
    logic [30:0] new_layout;
  } out_t;

  // Current state of one resource, cleared after reset.
  typedef struct packed {
    logic [30:0] layout;
    logic [63:0] stages;
    logic [63:0] access;
    logic        used;
    logic        written;
    logic        last_wr;
  } entry_t;

  // Masks of the latest write to one resource.
  typedef struct packed {
    logic [63:0] stages;
    logic [63:0] access;
  } wmask_t;

  // Write-back request from the hazard logic to the table.
  typedef struct packed {
    logic   en;
    logic   wmask_en;
    entry_t entry;
    wmask_t wmask;
  } wr_req_t;

endpackage

/* design/rbt_table.sv */
// Resource state table: entry and write-mask memories, clearing pass and forwarding.
module rbt_table import rbt_pkg::*; #(
  parameter int RESOURCES = RESOURCES_DEF,
  parameter int AW        = $clog2(RESOURCES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  wr_req_t       wr_i,
  output entry_t        rd_entry_o,
  output wmask_t        rd_wmask_o,
  output logic          clearing_o
);

  entry_t entry_mem [RESOURCES];
  wmask_t wmask_mem [RESOURCES];

  entry_t          ent_rd_q;
  wmask_t          wm_rd_q;
  logic            clr_active_q;
  logic [AW-1:0]   clr_cnt_q;
  logic            fwd_ent_hit_q;
  logic            fwd_wm_hit_q;
  entry_t          fwd_ent_q;
  wmask_t          fwd_wm_q;

  logic            ent_we;
  logic [AW-1:0]   ent_waddr;
  entry_t          ent_wdata;
  logic            same_addr;

  // Clearing pass walks every entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(RESOURCES - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  assign clearing_o = clr_active_q;

  // The entry write port is shared between the clearing pass and write-back.
  always_comb begin
    if (clr_active_q) begin
      ent_we    = 1'b1;
      ent_waddr = clr_cnt_q;
      ent_wdata = '0;
    end else begin
      ent_we    = wr_i.en;
      ent_waddr = wr_addr_i;
      ent_wdata = wr_i.entry;
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (rd_en_i) begin
      ent_rd_q <= entry_mem[rd_addr_i];
    end
  end

  // Write-mask memory; entries hold meaning only once the written mark is set.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.wmask_en) begin
      wmask_mem[wr_addr_i] <= wr_i.wmask;
    end
    if (rd_en_i) begin
      wm_rd_q <= wmask_mem[rd_addr_i];
    end
  end

  // A read that meets a write-back to the same entry takes the written data.
  assign same_addr = (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_ent_hit_q <= 1'b0;
      fwd_wm_hit_q  <= 1'b0;
    end else if (rd_en_i) begin
      fwd_ent_hit_q <= wr_i.en && same_addr;
      fwd_wm_hit_q  <= wr_i.en && wr_i.wmask_en && same_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_ent_q <= wr_i.entry;
      fwd_wm_q  <= wr_i.wmask;
    end
  end

  assign rd_entry_o = fwd_ent_hit_q ? fwd_ent_q : ent_rd_q;
  assign rd_wmask_o = fwd_wm_hit_q ? fwd_wm_q : wm_rd_q;

endmodule

/* design/rbt_hazard.sv */
// Hazard check and entry update for one item against its table entry.
module rbt_hazard import rbt_pkg::*; (
  input  logic    valid_i,
  input  logic    in_range_i,
  input  in_t     item_i,
  input  entry_t  entry_i,
  input  wmask_t  wmask_i,
  output wr_req_t wr_o,
  output out_t    result_o
);

  logic [63:0] src_stages;
  logic [63:0] src_access;
  logic        differs;

  // Source masks include the latest write once the entry has been written.
  assign src_stages = entry_i.stages | (entry_i.written ? wmask_i.stages : 64'd0);
  assign src_access = entry_i.access | (entry_i.written ? wmask_i.access : 64'd0);

  assign differs = (entry_i.layout != item_i.layout) ||
                   (entry_i.stages != item_i.stages) ||
                   (entry_i.access != item_i.access);

  always_comb begin
    wr_o            = '0;
    result_o        = '0;
    wr_o.wmask.stages = item_i.stages;
    wr_o.wmask.access = item_i.access;
    wr_o.entry.layout = item_i.layout;
    wr_o.entry.stages = item_i.stages;
    wr_o.entry.access = item_i.access;
    if (valid_i && in_range_i) begin
      unique case (item_i.opcode)
        OP_DEFINE: begin
          // Load the initial state and clear the marks; the result stays zero.
          wr_o.en = 1'b1;
        end
        OP_USE: begin
          wr_o.en              = 1'b1;
          wr_o.wmask_en        = item_i.is_write;
          wr_o.entry.used      = 1'b1;
          wr_o.entry.written   = entry_i.written | item_i.is_write;
          wr_o.entry.last_wr   = item_i.is_write;
          result_o.barrier     = !entry_i.used || entry_i.last_wr ||
                                 item_i.is_write || differs;
          result_o.src_stages  = src_stages;
          result_o.src_access  = src_access;
          result_o.dst_stages  = item_i.stages;
          result_o.dst_access  = item_i.access;
          result_o.old_layout  = entry_i.layout;
          result_o.new_layout  = item_i.layout;
        end
        default: begin
          wr_o.en = 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/resource_barrier_tracker_top.sv */
// Top level of the resource barrier tracker.
//
// Takes one item per clock cycle while busy is low and gives exactly one result
// beat per item, marked by done_o after the item stage and the result register;
// results come out in item order and cannot be held off by the receiver. The state
// table reads the entry at the accepting edge and writes it back in the next cycle,
// and a forwarding register covers an item that follows another on the same resource.
// After reset the table runs a clearing pass over every entry with busy high;
// from then on busy stays low. Define items and items whose resource index is
// RESOURCES or above give a result with all fields zero; the latter leave the
// table unchanged.
module resource_barrier_tracker_top import rbt_pkg::*; #(
  parameter int RESOURCES = RESOURCES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  localparam int AW = $clog2(RESOURCES);
  localparam int IW = (AW > 8) ? AW : 8;

  logic [IW-1:0] res_ext;
  logic [AW-1:0] rd_addr;
  logic          in_range;
  logic          accept;
  logic          clearing;

  logic          s1_valid_q;
  logic          s1_in_range_q;
  logic [AW-1:0] s1_addr_q;
  in_t           s1_item_q;

  entry_t        rd_entry;
  wmask_t        rd_wmask;
  wr_req_t       wr_req;
  out_t          result_d;
  logic          done_q;
  out_t          result_q;

  // Address and range check of the incoming beat.
  assign res_ext  = IW'(item_i.resource);
  assign rd_addr  = res_ext[AW-1:0];
  assign in_range = 32'(item_i.resource) < 32'(RESOURCES);
  assign busy     = clearing;
  assign accept   = start && !busy;

  // Item stage, aligned with the table read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q     <= item_i;
      s1_addr_q     <= rd_addr;
      s1_in_range_q <= in_range;
    end
  end

  rbt_table #(
    .RESOURCES (RESOURCES),
    .AW        (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (s1_addr_q),
    .wr_i       (wr_req),
    .rd_entry_o (rd_entry),
    .rd_wmask_o (rd_wmask),
    .clearing_o (clearing)
  );

  rbt_hazard u_hazard (
    .valid_i    (s1_valid_q),
    .in_range_i (s1_in_range_q),
    .item_i     (s1_item_q),
    .entry_i    (rd_entry),
    .wmask_i    (rd_wmask),
    .wr_o       (wr_req),
    .result_o   (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // Every accepted beat gives a result through the item stage and the result register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item gave no result");

  // No result without an accepted beat ahead of the item stage and the result register.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without an accepted item");

  // A define gives an all-zero result.
  a_define_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.opcode == OP_DEFINE) |=> ##1 (result_o == '0))
    else $error("define item gave a nonzero result");

  // A writing use within range always reports a barrier.
  a_write_barrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.opcode == OP_USE) && item_i.is_write && in_range
    |=> ##1 result_o.barrier)
    else $error("writing use without a barrier");

  // The table is not written back while the clearing pass runs.
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !wr_req.en)
    else $error("write-back during clearing pass");
`endif

endmodule

/* sim/tb_resource_barrier_tracker_top.sv */
// Self-checking testbench for the resource barrier tracker top level.
module tb_resource_barrier_tracker_top;
  import rbt_pkg::*;

  localparam int NUM_RES          = RESOURCES_DEF;
  localparam int TARGET_ITEMS     = 1750;
  localparam int STALL_LIMIT      = 2000;
  localparam int SHOWN_MISMATCHES = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic done_o;
  out_t result_o;

  // Shadow copy of the hazard table and of the latest write masks.
  entry_t hazard_state [NUM_RES];
  wmask_t last_write   [NUM_RES];

  // Barrier reports still owed by the block, oldest first.
  out_t pending_reports [$];

  int items_sent    = 0;
  int defines_seen  = 0;
  int uses_seen     = 0;
  int barriers_due  = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int gapless_left  = 0;

  resource_barrier_tracker_top #(
    .RESOURCES(NUM_RES)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the report for one accepted beat and updates the shadow table.
  function automatic out_t predict_barrier(in_t it);
    out_t   rep;
    entry_t ent;
    int     idx;
    rep = '0;
    idx = int'(it.resource);
    if (idx >= NUM_RES) return rep;
    if (it.opcode == OP_DEFINE) begin
      ent         = '0;
      ent.layout  = it.layout;
      ent.stages  = it.stages;
      ent.access  = it.access;
      hazard_state[idx] = ent;
      return rep;
    end
    ent = hazard_state[idx];
    rep.src_stages = ent.stages;
    rep.src_access = ent.access;
    // A past write keeps contributing to the source scope.
    if (ent.written) begin
      rep.src_stages = rep.src_stages | last_write[idx].stages;
      rep.src_access = rep.src_access | last_write[idx].access;
    end
    rep.barrier = !ent.used || ent.last_wr || it.is_write ||
                  ent.layout != it.layout || ent.stages != it.stages ||
                  ent.access != it.access;
    rep.dst_stages = it.stages;
    rep.dst_access = it.access;
    rep.old_layout = ent.layout;
    rep.new_layout = it.layout;
    // The use becomes the entry's current state.
    ent.layout = it.layout;
    ent.stages = it.stages;
    ent.access = it.access;
    ent.used   = 1'b1;
    if (it.is_write) begin
      last_write[idx].stages = it.stages;
      last_write[idx].access = it.access;
      ent.written = 1'b1;
    end
    ent.last_wr = it.is_write;
    hazard_state[idx] = ent;
    return rep;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // Checks each result beat, predicts each accepted beat and guards against hangs.
  always @(posedge clk_i) begin : scoreboard
    out_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("Result beat with nothing pending: %p", result_o);
        end else begin
          want = pending_reports.pop_front();
          check_field("barrier",    64'(want.barrier),    64'(result_o.barrier));
          check_field("src_stages", want.src_stages,      result_o.src_stages);
          check_field("src_access", want.src_access,      result_o.src_access);
          check_field("dst_stages", want.dst_stages,      result_o.dst_stages);
          check_field("dst_access", want.dst_access,      result_o.dst_access);
          check_field("old_layout", 64'(want.old_layout), 64'(result_o.old_layout));
          check_field("new_layout", 64'(want.new_layout), 64'(result_o.new_layout));
        end
      end
      if (start && !busy) begin
        want = predict_barrier(item_i);
        pending_reports = {pending_reports, want};
        if (item_i.opcode == OP_DEFINE) defines_seen++;
        else uses_seen++;
        if (want.barrier) barriers_due++;
      end
      // Watchdog on cycles with neither an accepted beat nor a result.
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles.", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic in_t make_item(logic op, logic [7:0] res, logic [30:0] lay,
                                    logic [63:0] stg, logic [63:0] acc, logic wr);
    in_t it;
    it.opcode   = op;
    it.resource = res;
    it.layout   = lay;
    it.stages   = stg;
    it.access   = acc;
    it.is_write = wr;
    return it;
  endfunction

  // Masks are drawn from a mix of dense, sparse and extreme values.
  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return {64{$urandom_range(0, 1) == 1}};
      default: return 64'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [30:0] rand_layout();
    case ($urandom_range(0, 3))
      0:       return 31'($urandom);
      1:       return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(0, 3));
    endcase
  endfunction

  // Sends one beat after a random gap and returns once it has been accepted.
  task automatic send_item(in_t it);
    int gap;
    if (gapless_left > 0) begin
      gap = 0;
      gapless_left--;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) gapless_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Holds the sender off until every pending report has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes and each reason for a barrier, in a fixed order.
  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    // An entry never defined still starts out unused.
    send_item(make_item(OP_USE, 8'd5, 31'd0, 64'd0, 64'd0, 1'b0));
    send_item(make_item(OP_USE, 8'd5, 31'd0, 64'd0, 64'd0, 1'b0));
    // Define with the widest values; the write flag is ignored here.
    send_item(make_item(OP_DEFINE, 8'd0, 31'h7FFF_FFFF, ones, ones, 1'b1));
    send_item(make_item(OP_USE, 8'd0, 31'h7FFF_FFFF, ones, ones, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'h7FFF_FFFF, ones, ones, 1'b0));
    // A write, then reads that see the write masks in the source scope.
    send_item(make_item(OP_USE, 8'd0, 31'd7, 64'h0F, 64'hF0, 1'b1));
    send_item(make_item(OP_USE, 8'd0, 31'd7, 64'h0F, 64'hF0, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'd7, 64'h0F, 64'hF0, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'd3, 64'h0F, 64'hF0, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'd3, 64'h1F, 64'hF0, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'd3, 64'h1F, 64'hF1, 1'b0));
    // A new define clears the used, written and last-write marks.
    send_item(make_item(OP_DEFINE, 8'd0, 31'd3, 64'h1F, 64'hF1, 1'b0));
    send_item(make_item(OP_USE, 8'd0, 31'd3, 64'h1F, 64'hF1, 1'b0));
    // Buffer at the top index, then back-to-back writes.
    send_item(make_item(OP_DEFINE, 8'd255, 31'd0, 64'd0, 64'd0, 1'b0));
    send_item(make_item(OP_USE, 8'd255, 31'd0, 64'd0, 64'd0, 1'b0));
    send_item(make_item(OP_USE, 8'd255, 31'd0, 64'd0, 64'd0, 1'b0));
    send_item(make_item(OP_USE, 8'd255, 31'd0, 64'h8000_0000_0000_0001,
                        64'h5555_5555_5555_5555, 1'b1));
    send_item(make_item(OP_USE, 8'd255, 31'd0, 64'h2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    send_item(make_item(OP_USE, 8'd255, 31'd0, 64'h2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
    send_item(make_item(OP_DEFINE, 8'd128, 31'h4000_0000, 64'd0, ones, 1'b0));
    send_item(make_item(OP_USE, 8'd128, 31'h4000_0000, 64'd0, ones, 1'b0));
  endtask

  // Two uses of one entry, a full drain, then two more uses of the same entry.
  task automatic test_drain_pause();
    send_item(make_item(OP_USE, 8'd42, 31'd1, 64'h10, 64'h20, 1'b1));
    send_item(make_item(OP_USE, 8'd42, 31'd1, 64'h10, 64'h20, 1'b0));
    wait_for_drain();
    send_item(make_item(OP_USE, 8'd42, 31'd1, 64'h10, 64'h20, 1'b0));
    send_item(make_item(OP_USE, 8'd42, 31'd1, 64'h10, 64'h20, 1'b0));
  endtask

  // Mostly define-then-use sequences on a few hot entries, plus random noise.
  task automatic test_random_traffic();
    logic [7:0]  res;
    logic [30:0] lay;
    logic [63:0] stg;
    logic [63:0] acc;
    int          uses;
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            31'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                            1'($urandom_range(0, 1))));
      end else begin
        res = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 15));
        lay = rand_layout();
        stg = rand_mask();
        acc = rand_mask();
        if ($urandom_range(0, 2) != 0)
          send_item(make_item(OP_DEFINE, res, lay, stg, acc, 1'($urandom_range(0, 1))));
        uses = $urandom_range(1, 6);
        repeat (uses) begin
          // Half of the uses keep the last layout and masks so that hazard-free beats show up.
          case ($urandom_range(0, 5))
            0:       lay = rand_layout();
            1:       stg = rand_mask();
            2:       acc = rand_mask();
            default: ;
          endcase
          send_item(make_item(OP_USE, res, lay, stg, acc, $urandom_range(0, 3) == 0));
        end
      end
      if ($urandom_range(0, 49) == 0) wait_for_drain();
    end
  endtask

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    for (int i = 0; i < NUM_RES; i++) begin
      hazard_state[i] = '0;
      last_write[i]   = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_drain_pause();
    test_random_traffic();

    wait_for_drain();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d beats: %0d defines and %0d uses, %0d of them needing a barrier.",
             items_sent, defines_seen, uses_seen, barriers_due);
    $display("Field mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
design/rbt_pkg.sv
design/rbt_table.sv
design/rbt_hazard.sv
design/resource_barrier_tracker_top.sv
sim/tb_resource_barrier_tracker_top.sv
